### rtl/core/mi_pkg.sv
// Shared types, widths and index helpers for the 4x4 matrix inverse.
`default_nettype none
package mi_pkg;

    localparam int ELEM_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DIG_W         = 33;   // multiplier operand: one signed 33-bit digit
    localparam int PROD_W        = 66;
    localparam int MIN_W         = 65;   // 2x2 minor
    localparam int ADJ_W         = 97;   // 3x3 minor / cofactor
    localparam int DET_W         = 130;  // determinant
    localparam int ACC_W         = 136;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);
    localparam int Q_BITS        = 34;   // quotient bits kept, top two flag overflow
    localparam int DIV_STEPS     = Q_BITS;

    // accumulator destinations
    localparam logic [1:0] DST_MIN = 2'd0;
    localparam logic [1:0] DST_COF = 2'd1;
    localparam logic [1:0] DST_DET = 2'd2;

    typedef logic [15:0][ELEM_W-1:0] matrix_t;

    typedef struct packed {
        logic       valid;
        logic       sub;
        logic       first;
        logic       wr;
        logic [1:0] kind;
        logic [1:0] p;
        logic [2:0] q;
        logic [1:0] dig;
    } mac_ctl_t;

    // t-th column of the three left when column k is removed
    function automatic logic [1:0] col_skip(input logic [1:0] k, input logic [1:0] t);
        return (t < k) ? t : t + 2'd1;
    endfunction

    // index of an ordered column pair
    function automatic logic [2:0] pair_idx(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] r;
        case ({a, b})
            4'b0001: r = 3'd0;
            4'b0010: r = 3'd1;
            4'b0011: r = 3'd2;
            4'b0110: r = 3'd3;
            4'b0111: r = 3'd4;
            4'b1011: r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // columns {a,b} of a column pair
    function automatic logic [3:0] pair_cols(input logic [2:0] cp);
        logic [3:0] r;
        case (cp)
            3'd0:    r = {2'd0, 2'd1};
            3'd1:    r = {2'd0, 2'd2};
            3'd2:    r = {2'd0, 2'd3};
            3'd3:    r = {2'd1, 2'd2};
            3'd4:    r = {2'd1, 2'd3};
            3'd5:    r = {2'd2, 2'd3};
            default: r = {2'd0, 2'd1};
        endcase
        return r;
    endfunction

    // rows {a,b} of the row pairs whose 2x2 minors are kept
    function automatic logic [3:0] pair_rows(input logic [1:0] rp);
        logic [3:0] r;
        case (rp)
            2'd0:    r = {2'd2, 2'd3};
            2'd1:    r = {2'd1, 2'd3};
            2'd2:    r = {2'd1, 2'd2};
            default: r = {2'd2, 2'd3};
        endcase
        return r;
    endfunction

    // row pair used by the 3x3 minor that drops row r
    function automatic logic [1:0] rowpair_of(input logic [1:0] r);
        logic [1:0] rp;
        case (r)
            2'd0:    rp = 2'd0;
            2'd1:    rp = 2'd0;
            2'd2:    rp = 2'd1;
            2'd3:    rp = 2'd2;
            default: rp = 2'd0;
        endcase
        return rp;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mi_front.sv
// Front end: gathers sixteen elements into one matrix and pushes it to the queue.
`default_nettype none
module mi_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic signed [31:0]  element_value,
    input  wire logic                element_valid,
    output logic                     element_stall,
    output logic                     push,
    output mi_pkg::matrix_t          push_data,
    input  wire logic                q_full
);
    import mi_pkg::*;

    logic [3:0]                   count_reg;
    logic [3:0]                   count_next;
    logic [14:0][ELEM_W-1:0]      asm_reg;
    logic                         accept;

    // hold the sixteenth item back while the queue has no room
    assign element_stall = (count_reg == 4'd15) && q_full;
    assign accept        = element_valid && !element_stall;
    assign push          = accept && (count_reg == 4'd15);
    assign push_data     = {element_value, asm_reg};

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // assembly buffer
    always_ff @(posedge clk)
    begin
        if (accept && (count_reg != 4'd15))
        begin
            asm_reg[count_reg] <= element_value;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mi_queue.sv
// Two-deep matrix queue between front and back.
`default_nettype none
module mi_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mi_pkg::matrix_t  push_data,
    input  wire logic             pop,
    output mi_pkg::matrix_t       head,
    output logic                  full,
    output logic                  empty
);
    import mi_pkg::*;

    matrix_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]    cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/mi_back.sv
// Back end: cofactors and determinant on one multiply-accumulate unit, then
// a bit-serial divider per inverse element and the result register.
`default_nettype none
module mi_back #(
    parameter int FRAC_BITS = mi_pkg::FRAC_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire mi_pkg::matrix_t  head,
    output logic                  pop,
    output logic signed [31:0]    inverse_value,
    output logic                  singular,
    output logic                  last_element,
    output logic                  result_valid,
    input  wire logic             result_stall
);
    import mi_pkg::*;

    localparam int NUM_W = ADJ_W + 2 * FRAC_BITS + 2;
    localparam int RW    = (NUM_W > DET_W + DIV_STEPS) ? NUM_W : DET_W + DIV_STEPS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MIN   = 4'd1;
    localparam logic [3:0] ST_COF   = 4'd2;
    localparam logic [3:0] ST_DET   = 4'd3;
    localparam logic [3:0] ST_DRAIN = 4'd4;
    localparam logic [3:0] ST_DCHK  = 4'd5;
    localparam logic [3:0] ST_DSET  = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [1:0]              p_reg, p_next;
    logic [2:0]              q_reg, q_next;
    logic [1:0]              term_reg, term_next;
    logic [1:0]              dig_reg, dig_next;
    logic [5:0]              step_reg, step_next;

    logic [7:0][ELEM_W-1:0]  r23_reg;
    logic [MIN_W-1:0]        minor_reg [3][6];
    logic [ADJ_W-1:0]        cof_reg [16];
    logic [DET_W-1:0]        det_reg;
    logic [DET_W-1:0]        dabs_reg;
    logic                    dneg_reg;
    logic                    sing_reg;
    logic [ACC_W-1:0]        acc_reg;
    mac_ctl_t                ctl_reg, ctl_n;
    logic signed [PROD_W-1:0] prod_reg;

    logic [RW-1:0]           rem_reg;
    logic [RW-1:0]           dsh_reg;
    logic [Q_BITS-1:0]       quo_reg;
    logic                    rneg_reg;

    logic                    ovalid_reg;
    logic [31:0]             oval_reg;
    logic                    osing_reg;
    logic                    olast_reg;

    logic [3:0]              a_idx;
    logic [ELEM_W-1:0]       a_elem;
    logic signed [DIG_W-1:0] a_dig;
    logic signed [DIG_W-1:0] b_dig;
    logic                    capture;
    logic                    load_out;
    logic                    out_free;
    logic [31:0]             sat_val;

    // operand selection for the multiply-accumulate unit
    always_comb
    begin
        logic [3:0]        rows;
        logic [3:0]        cols;
        logic [ELEM_W-1:0] belem;
        logic [1:0]        ct, cu, cv, rp, r0;
        logic [2:0]        cp;
        logic [MIN_W-1:0]  mv;
        logic [ADJ_W-1:0]  cv_w;
        rows  = pair_rows(p_reg);
        cols  = pair_cols(q_reg);
        belem = '0;
        ct    = col_skip(q_reg[1:0], term_reg);
        cu    = col_skip(q_reg[1:0], (term_reg == 2'd0) ? 2'd1 : 2'd0);
        cv    = col_skip(q_reg[1:0], (term_reg == 2'd2) ? 2'd1 : 2'd2);
        cp    = pair_idx(cu, cv);
        rp    = rowpair_of(p_reg);
        r0    = (p_reg == 2'd0) ? 2'd1 : 2'd0;
        mv    = minor_reg[rp][cp];
        cv_w  = cof_reg[{2'b00, q_reg[1:0]}];
        a_idx = '0;
        b_dig = '0;
        ctl_n = '0;
        case (state_reg)
            ST_MIN:
            begin
                if (term_reg == 2'd0)
                begin
                    a_idx = {rows[3:2], cols[3:2]};
                    belem = r23_reg[{rows[0], cols[1:0]}];
                end
                else
                begin
                    a_idx = {rows[3:2], cols[1:0]};
                    belem = r23_reg[{rows[0], cols[3:2]}];
                end
                b_dig       = {belem[ELEM_W-1], belem};
                ctl_n.valid = 1'b1;
                ctl_n.sub   = (term_reg != 2'd0);
                ctl_n.first = (term_reg == 2'd0);
                ctl_n.wr    = (term_reg != 2'd0);
                ctl_n.kind  = DST_MIN;
                ctl_n.p     = p_reg;
                ctl_n.q     = q_reg;
                ctl_n.dig   = 2'd0;
            end
            ST_COF:
            begin
                a_idx       = {r0, ct};
                b_dig       = (dig_reg == 2'd0) ? {1'b0, mv[31:0]} : mv[64:32];
                ctl_n.valid = 1'b1;
                ctl_n.sub   = term_reg[0] ^ p_reg[0] ^ q_reg[0];
                ctl_n.first = (term_reg == 2'd0) && (dig_reg == 2'd0);
                ctl_n.wr    = (term_reg == 2'd2) && (dig_reg == 2'd1);
                ctl_n.kind  = DST_COF;
                ctl_n.p     = p_reg;
                ctl_n.q     = q_reg;
                ctl_n.dig   = dig_reg;
            end
            ST_DET:
            begin
                a_idx = {2'b00, q_reg[1:0]};
                case (dig_reg)
                    2'd0:    b_dig = {1'b0, cv_w[31:0]};
                    2'd1:    b_dig = {1'b0, cv_w[63:32]};
                    default: b_dig = cv_w[96:64];
                endcase
                ctl_n.valid = 1'b1;
                ctl_n.sub   = 1'b0;
                ctl_n.first = (q_reg == 3'd0) && (dig_reg == 2'd0);
                ctl_n.wr    = (q_reg == 3'd3) && (dig_reg == 2'd2);
                ctl_n.kind  = DST_DET;
                ctl_n.p     = p_reg;
                ctl_n.q     = q_reg;
                ctl_n.dig   = dig_reg;
            end
            default:
            begin
                ctl_n = '0;
            end
        endcase
    end

    assign a_elem = head[a_idx];
    assign a_dig  = {a_elem[ELEM_W-1], a_elem};

    // multiplier stage
    always_ff @(posedge clk)
    begin
        prod_reg <= a_dig * b_dig;
    end

    // accumulate stage and result stores
    always_ff @(posedge clk)
    begin
        logic [ACC_W-1:0] pext, sh, base, nxt;
        pext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (ctl_reg.dig)
            2'd0:    sh = pext;
            2'd1:    sh = pext << 32;
            default: sh = pext << 64;
        endcase
        base = ctl_reg.first ? '0 : acc_reg;
        nxt  = ctl_reg.sub ? base - sh : base + sh;
        if (ctl_reg.valid)
        begin
            acc_reg <= nxt;
            if (ctl_reg.wr)
            begin
                case (ctl_reg.kind)
                    DST_MIN: minor_reg[ctl_reg.p][ctl_reg.q] <= nxt[MIN_W-1:0];
                    DST_COF: cof_reg[{ctl_reg.p, ctl_reg.q[1:0]}] <= nxt[ADJ_W-1:0];
                    DST_DET: det_reg <= nxt[DET_W-1:0];
                    default: acc_reg <= nxt;
                endcase
            end
        end
    end

    // sequencer
    assign out_free = !ovalid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        term_next  = term_reg;
        dig_next   = dig_reg;
        step_next  = step_reg;
        capture    = 1'b0;
        load_out   = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    capture    = 1'b1;
                    state_next = ST_MIN;
                    p_next     = '0;
                    q_next     = '0;
                    term_next  = '0;
                    dig_next   = '0;
                end
            end
            ST_MIN:
            begin
                if (term_reg == 2'd0)
                begin
                    term_next = 2'd1;
                end
                else
                begin
                    term_next = 2'd0;
                    if (q_reg == 3'd5)
                    begin
                        q_next = '0;
                        if (p_reg == 2'd2)
                        begin
                            p_next     = '0;
                            state_next = ST_COF;
                        end
                        else
                        begin
                            p_next = p_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        q_next = q_reg + 3'd1;
                    end
                end
            end
            ST_COF:
            begin
                if (dig_reg == 2'd0)
                begin
                    dig_next = 2'd1;
                end
                else
                begin
                    dig_next = 2'd0;
                    if (term_reg != 2'd2)
                    begin
                        term_next = term_reg + 2'd1;
                    end
                    else
                    begin
                        term_next = 2'd0;
                        if (q_reg == 3'd3)
                        begin
                            q_next = '0;
                            if (p_reg == 2'd3)
                            begin
                                p_next     = '0;
                                state_next = ST_DET;
                            end
                            else
                            begin
                                p_next = p_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            q_next = q_reg + 3'd1;
                        end
                    end
                end
            end
            ST_DET:
            begin
                if (dig_reg != 2'd2)
                begin
                    dig_next = dig_reg + 2'd1;
                end
                else
                begin
                    dig_next = 2'd0;
                    if (q_reg == 3'd3)
                    begin
                        q_next     = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        q_next = q_reg + 3'd1;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DCHK;
            end
            ST_DCHK:
            begin
                state_next = ST_DSET;
            end
            ST_DSET:
            begin
                step_next  = '0;
                state_next = sing_reg ? ST_EMIT : ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if ((p_reg == 2'd3) && (q_reg == 3'd3))
                    begin
                        pop        = 1'b1;
                        p_next     = '0;
                        q_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DSET;
                        if (q_reg == 3'd3)
                        begin
                            q_next = '0;
                            p_next = p_reg + 2'd1;
                        end
                        else
                        begin
                            q_next = q_reg + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            p_reg      <= '0;
            q_reg      <= '0;
            term_reg   <= '0;
            dig_reg    <= '0;
            step_reg   <= '0;
            ctl_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            term_reg  <= term_next;
            dig_reg   <= dig_next;
            step_reg  <= step_next;
            ctl_reg   <= ctl_n;
            if (load_out)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // local copy of rows 2 and 3, determinant check, divider
    always_ff @(posedge clk)
    begin
        logic [ADJ_W-1:0] adj;
        logic [ADJ_W-1:0] adj_abs;
        logic             ge;
        adj     = cof_reg[{q_reg[1:0], p_reg}];
        adj_abs = adj[ADJ_W-1] ? (~adj + 1'b1) : adj;
        ge      = (rem_reg >= dsh_reg);
        if (capture)
        begin
            r23_reg <= head[15:8];
        end
        if (state_reg == ST_DCHK)
        begin
            dneg_reg <= det_reg[DET_W-1];
            dabs_reg <= det_reg[DET_W-1] ? (~det_reg + 1'b1) : det_reg;
            sing_reg <= (det_reg == '0);
        end
        if (state_reg == ST_DSET)
        begin
            rem_reg  <= (RW'(adj_abs) << (2 * FRAC_BITS + 1)) + RW'(dabs_reg);
            dsh_reg  <= RW'(dabs_reg) << DIV_STEPS;
            quo_reg  <= '0;
            rneg_reg <= adj[ADJ_W-1] ^ dneg_reg;
        end
        if (state_reg == ST_DIV)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[Q_BITS-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // round-to-nearest quotient saturated to 32 bits
    always_comb
    begin
        if (sing_reg)
        begin
            sat_val = '0;
        end
        else if (rneg_reg)
        begin
            sat_val = (quo_reg > Q_BITS'(34'h080000000)) ? 32'h80000000
                                                           : (32'd0 - quo_reg[31:0]);
        end
        else
        begin
            sat_val = (quo_reg > Q_BITS'(34'h07FFFFFFF)) ? 32'h7FFFFFFF : quo_reg[31:0];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            oval_reg  <= sat_val;
            osing_reg <= sing_reg;
            olast_reg <= (p_reg == 2'd3) && (q_reg == 3'd3);
        end
    end

    assign inverse_value = oval_reg;
    assign singular      = osing_reg;
    assign last_element  = olast_reg;
    assign result_valid  = ovalid_reg;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && osing_reg) |-> (oval_reg == '0))
        else $error("singular item carries a non-zero value");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("queue popped while empty");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ctl_reg.valid)
        else $error("multiply-accumulate busy while idle");

endmodule
`default_nettype wire

### rtl/core/matrix_inverse_4x4.sv
// Top level of the 4x4 fixed-point matrix inverse.
// Sixteen signed elements enter in row-major order; the block returns the
// sixteen elements of the inverse (adjugate scaled by 1/determinant, rounded
// to nearest, ties away from zero, saturated), last_element on the final one,
// or sixteen zeros with singular set when the determinant is zero. The back
// end does the cofactor and determinant work on a single 33x33
// multiply-accumulate unit, then runs a one-bit-per-cycle divider once per
// element (a singular matrix skips it). Loading is one element per cycle
// unless element_stall holds the sixteenth back while the queue is full,
// and proceeds into a two-deep matrix queue while the back end works, so
// the sustained rate is set by the back end.
`default_nettype none
module matrix_inverse_4x4 #(
    parameter int FRAC_BITS = mi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic signed [31:0]  element_value,
    input  wire logic                element_valid,
    output logic                     element_stall,
    output logic signed [31:0]       inverse_value,
    output logic                     singular,
    output logic                     last_element,
    output logic                     result_valid,
    input  wire logic                result_stall
);
    import mi_pkg::*;

    matrix_t push_data;
    matrix_t head;
    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;

    mi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_value (element_value),
        .element_valid (element_valid),
        .element_stall (element_stall),
        .push          (push),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    mi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    mi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .inverse_value (inverse_value),
        .singular      (singular),
        .last_element  (last_element),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

endmodule
`default_nettype wire
